// ===== design/pfsn_pkg.sv =====
// shared types and constants for the plane fit and normalize block
package pfsn_pkg;

    localparam int MAX_DIM_DEF = 256;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = 40;
    localparam int SUMV_W      = 24;
    localparam int COEF_W      = 40;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_W       = 58;
    localparam int DEN_W       = 41;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PASS     = 2'd1;
    localparam logic [1:0] ST_NOT_LOAD = 2'd2;

    localparam logic signed [COEF_W-1:0] MIN_RESET = {1'b0, {(COEF_W-1){1'b1}}};

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel_in;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [1:0]       status;
        logic             last_pixel;
    } out_word_t;

endpackage

// ===== design/pfsn_ram.sv =====
// generic single write port ram with registered read
module pfsn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/pfsn_div.sv =====
// bit serial restoring divider, signed numerator, unsigned divisor, truncating
module pfsn_div #(
    parameter int NW = pfsn_pkg::NUM_W,
    parameter int DW = pfsn_pkg::DEN_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic                 busy,
    output logic                 done,
    output logic signed [NW-1:0] quo
);

    localparam int MW = NW - 1;
    localparam int CW = $clog2(MW + 1);

    logic [MW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [NW-1:0] num_abs;
    logic [DW:0]   rem_sh;
    logic [DW+1:0] diff;

    assign num_abs = num[NW-1] ? -num : num;
    assign rem_sh  = {rem_reg, q_reg[MW-1]};
    assign diff    = {1'b0, rem_sh} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                q_reg    <= num_abs[MW-1:0];
                rem_reg  <= '0;
                den_reg  <= den;
                neg_reg  <= num[NW-1];
                cnt_reg  <= CW'(MW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!diff[DW+1])
                begin
                    rem_reg <= diff[DW-1:0];
                    q_reg   <= {q_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[DW-1:0];
                    q_reg   <= {q_reg[MW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

// ===== design/plane_fit_subtract_normalize.sv =====
// top level: image store, plane fit sequencer and readout normalization
//
//  channel | direction | word          | handshake
//  in      | input     | in_word_t     | in_valid / in_ready
//  out     | output    | out_word_t    | out_valid / out_ready
//  cfg     | input     | index, data   | cfg_valid / cfg_ready
//
// the last load of an image starts the fit when both dimensions are two or more:
// three divisions on the shared divider, then a min/max sweep of the image through
// the image ram port, with a read state and an evaluate state per pixel
// a readout word takes a read and an evaluate state, plus the normalizing division
// in_ready is low while the sequencer runs, a result waits or a config word is offered
// cfg_ready is high only while the sequencer is idle; no clearing pass
module plane_fit_subtract_normalize #(
    parameter int MAX_DIM = pfsn_pkg::MAX_DIM_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  pfsn_pkg::in_word_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output pfsn_pkg::out_word_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pfsn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfsn_pkg::CFG_W-1:0]       cfg_data
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int NW = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int SW = pfsn_pkg::SUM_W;
    localparam int CW = pfsn_pkg::COEF_W;
    localparam int QW = pfsn_pkg::NUM_W;
    localparam int EW = pfsn_pkg::DEN_W;
    localparam int PW = pfsn_pkg::PIX_W;
    localparam int FB = pfsn_pkg::FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_FA_GO, S_FA_WT, S_FB_GO, S_FB_WT, S_FC_GO, S_FC_WT,
        S_SC_RD, S_SC_EV, S_RO_RD, S_RO_EV, S_RO_WT
    } state_t;

    typedef enum logic [1:0] {PH_LOADING, PH_FITTED, PH_PASS} phase_t;

    state_t  state_reg;
    phase_t  phase_reg;

    logic [pfsn_pkg::CFG_W-1:0] row_count_reg;
    logic [pfsn_pkg::CFG_W-1:0] col_count_reg;

    logic signed [SW-1:0]       sum_col_sq_reg;
    logic signed [SW-1:0]       sum_row_sq_reg;
    logic signed [SW-1:0]       sum_col_val_reg;
    logic signed [SW-1:0]       sum_row_val_reg;
    logic [pfsn_pkg::SUMV_W-1:0] sum_val_reg;

    logic signed [CW-1:0] coef_a_reg;
    logic signed [CW-1:0] coef_b_reg;
    logic signed [CW-1:0] coef_c_reg;
    logic signed [CW-1:0] res_min_reg;
    logic signed [CW-1:0] res_max_reg;

    logic [NW-1:0]        pos_idx_reg;
    logic [DW-1:0]        pos_j_reg;
    logic [DW-1:0]        pos_i_reg;
    logic signed [CW-1:0] pos_pv_reg;
    logic signed [CW-1:0] pos_rb_reg;

    logic                 out_valid_reg;
    pfsn_pkg::out_word_t  out_data_reg;

    logic [DW-1:0]        rows;
    logic [DW-1:0]        cols;
    logic [2*DW-1:0]      n_full;
    logic [NW-1:0]        n;
    logic                 fresh;
    logic [NW-1:0]        eff_idx;
    logic [DW-1:0]        eff_j;
    logic [DW-1:0]        eff_i;
    logic                 end_row;
    logic                 end_img;
    logic                 pos_end_row;
    logic                 pos_end_img;
    logic signed [DW+1:0] jc;
    logic signed [DW+1:0] ic;
    logic signed [2*DW+3:0] jsq;
    logic signed [2*DW+3:0] isq;
    logic signed [DW+10:0]  jp;
    logic signed [DW+10:0]  ip;

    logic [PW-1:0]        ram_rdata;
    logic [AW-1:0]        ram_raddr;
    logic                 ram_we;

    logic signed [CW-1:0] resid;
    logic signed [CW:0]   x_off;
    logic signed [CW:0]   span;
    logic [CW+8:0]        x_scaled;

    logic                 div_start;
    logic signed [QW-1:0] div_num;
    logic [EW-1:0]        div_den;
    logic                 div_busy;
    logic                 div_done;
    logic signed [QW-1:0] div_quo;

    logic                 in_fire;
    logic                 cfg_fire;
    logic                 out_fire;

    function automatic logic [DW-1:0] eff_dim(input logic [pfsn_pkg::CFG_W-1:0] v);
        logic [DW-1:0] r;
        if (v == '0)
        begin
            r = DW'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            r = DW'(MAX_DIM);
        end
        else
        begin
            r = DW'(v);
        end
        return r;
    endfunction

    assign rows   = eff_dim(row_count_reg);
    assign cols   = eff_dim(col_count_reg);
    assign n_full = rows * cols;
    assign n      = NW'(n_full);

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_fire  = out_valid_reg && out_ready;

    // position of the current pixel, restarted for a fresh image
    assign fresh   = (phase_reg != PH_LOADING);
    assign eff_idx = fresh ? '0 : pos_idx_reg;
    assign eff_j   = fresh ? '0 : pos_j_reg;
    assign eff_i   = fresh ? '0 : pos_i_reg;
    assign end_row = (eff_j == cols - 1'b1);
    assign end_img = (eff_idx == n - 1'b1);

    // readout position
    assign pos_end_row = (pos_j_reg == cols - 1'b1);
    assign pos_end_img = (pos_idx_reg == n - 1'b1);

    // doubled centred coordinates
    assign jc  = $signed({1'b0, eff_j, 1'b0}) - $signed({2'b00, cols - 1'b1});
    assign ic  = $signed({1'b0, eff_i, 1'b0}) - $signed({2'b00, rows - 1'b1});
    assign jsq = jc * jc;
    assign isq = ic * ic;
    assign jp  = jc * $signed({1'b0, in_data.pixel_in});
    assign ip  = ic * $signed({1'b0, in_data.pixel_in});

    assign ram_we    = in_fire && !in_data.action;
    assign ram_raddr = pos_idx_reg[AW-1:0];

    pfsn_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (eff_idx[AW-1:0]),
        .wdata (in_data.pixel_in),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign resid    = $signed({{(CW-PW-FB){1'b0}}, ram_rdata, {FB{1'b0}}}) - pos_pv_reg;
    assign x_off    = $signed({resid[CW-1], resid}) - $signed({res_min_reg[CW-1], res_min_reg});
    assign span     = $signed({res_max_reg[CW-1], res_max_reg})
                    - $signed({res_min_reg[CW-1], res_min_reg});
    assign x_scaled = {x_off[CW:0], 8'b0} - {8'b0, x_off[CW:0]};

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            S_FA_GO:
            begin
                div_start = 1'b1;
                div_num   = QW'(sum_col_val_reg) <<< (FB + 1);
                div_den   = EW'(sum_col_sq_reg);
            end
            S_FB_GO:
            begin
                div_start = 1'b1;
                div_num   = QW'(sum_row_val_reg) <<< (FB + 1);
                div_den   = EW'(sum_row_sq_reg);
            end
            S_FC_GO:
            begin
                div_start = 1'b1;
                div_num   = $signed(QW'(sum_val_reg)) <<< FB;
                div_den   = EW'(n);
            end
            S_RO_EV:
            begin
                div_start = (phase_reg == PH_FITTED) && (span != '0);
                div_num   = $signed(QW'(x_scaled));
                div_den   = EW'(span);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    pfsn_div #(
        .NW (QW),
        .DW (EW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_LOADING;
            row_count_reg   <= pfsn_pkg::CFG_W'(1);
            col_count_reg   <= pfsn_pkg::CFG_W'(1);
            sum_col_sq_reg  <= '0;
            sum_row_sq_reg  <= '0;
            sum_col_val_reg <= '0;
            sum_row_val_reg <= '0;
            sum_val_reg     <= '0;
            coef_a_reg      <= '0;
            coef_b_reg      <= '0;
            coef_c_reg      <= '0;
            res_min_reg     <= pfsn_pkg::MIN_RESET;
            res_max_reg     <= '0;
            pos_idx_reg     <= '0;
            pos_j_reg       <= '0;
            pos_i_reg       <= '0;
            pos_pv_reg      <= '0;
            pos_rb_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_fire && (cfg_index == pfsn_pkg::CFG_ROW_COUNT
                             || cfg_index == pfsn_pkg::CFG_COL_COUNT))
            begin
                if (cfg_index == pfsn_pkg::CFG_ROW_COUNT)
                begin
                    row_count_reg <= cfg_data;
                end
                else
                begin
                    col_count_reg <= cfg_data;
                end
                phase_reg       <= PH_LOADING;
                pos_idx_reg     <= '0;
                pos_j_reg       <= '0;
                pos_i_reg       <= '0;
                sum_col_sq_reg  <= '0;
                sum_row_sq_reg  <= '0;
                sum_col_val_reg <= '0;
                sum_row_val_reg <= '0;
                sum_val_reg     <= '0;
                coef_a_reg      <= '0;
                coef_b_reg      <= '0;
                coef_c_reg      <= '0;
                res_min_reg     <= pfsn_pkg::MIN_RESET;
                res_max_reg     <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (in_fire && !in_data.action)
                        begin
                            sum_col_sq_reg  <= (fresh ? '0 : sum_col_sq_reg) + SW'(jsq);
                            sum_row_sq_reg  <= (fresh ? '0 : sum_row_sq_reg) + SW'(isq);
                            sum_col_val_reg <= (fresh ? '0 : sum_col_val_reg) + SW'(jp);
                            sum_row_val_reg <= (fresh ? '0 : sum_row_val_reg) + SW'(ip);
                            sum_val_reg     <= (fresh ? '0 : sum_val_reg)
                                             + pfsn_pkg::SUMV_W'(in_data.pixel_in);
                            res_min_reg     <= pfsn_pkg::MIN_RESET;
                            res_max_reg     <= '0;
                            if (end_img)
                            begin
                                pos_idx_reg <= '0;
                                pos_j_reg   <= '0;
                                pos_i_reg   <= '0;
                                if (rows < DW'(2) || cols < DW'(2))
                                begin
                                    phase_reg <= PH_PASS;
                                end
                                else
                                begin
                                    phase_reg <= PH_LOADING;
                                    state_reg <= S_FA_GO;
                                end
                            end
                            else
                            begin
                                phase_reg   <= PH_LOADING;
                                pos_idx_reg <= eff_idx + 1'b1;
                                pos_j_reg   <= end_row ? '0 : eff_j + 1'b1;
                                pos_i_reg   <= end_row ? eff_i + 1'b1 : eff_i;
                            end
                        end
                        else if (in_fire)
                        begin
                            if (phase_reg == PH_LOADING)
                            begin
                                out_data_reg.pixel_out  <= '0;
                                out_data_reg.status     <= pfsn_pkg::ST_NOT_LOAD;
                                out_data_reg.last_pixel <= 1'b0;
                                out_valid_reg           <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_RO_RD;
                            end
                        end
                    end
                    S_FA_GO:
                    begin
                        state_reg <= S_FA_WT;
                    end
                    S_FA_WT:
                    begin
                        if (div_done)
                        begin
                            coef_a_reg <= div_quo[CW-1:0];
                            state_reg  <= S_FB_GO;
                        end
                    end
                    S_FB_GO:
                    begin
                        state_reg <= S_FB_WT;
                    end
                    S_FB_WT:
                    begin
                        if (div_done)
                        begin
                            coef_b_reg <= div_quo[CW-1:0];
                            state_reg  <= S_FC_GO;
                        end
                    end
                    S_FC_GO:
                    begin
                        state_reg <= S_FC_WT;
                    end
                    S_FC_WT:
                    begin
                        if (div_done)
                        begin
                            coef_c_reg <= div_quo[CW-1:0];
                            pos_pv_reg <= div_quo[CW-1:0];
                            pos_rb_reg <= div_quo[CW-1:0];
                            state_reg  <= S_SC_RD;
                        end
                    end
                    S_SC_RD:
                    begin
                        state_reg <= S_SC_EV;
                    end
                    S_SC_EV:
                    begin
                        if (resid <= res_min_reg)
                        begin
                            res_min_reg <= resid;
                        end
                        if (resid >= res_max_reg)
                        begin
                            res_max_reg <= resid;
                        end
                        if (end_img)
                        begin
                            pos_idx_reg <= '0;
                            pos_j_reg   <= '0;
                            pos_i_reg   <= '0;
                            pos_pv_reg  <= coef_c_reg;
                            pos_rb_reg  <= coef_c_reg;
                            phase_reg   <= PH_FITTED;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            pos_idx_reg <= pos_idx_reg + 1'b1;
                            pos_j_reg   <= end_row ? '0 : pos_j_reg + 1'b1;
                            pos_i_reg   <= end_row ? pos_i_reg + 1'b1 : pos_i_reg;
                            pos_pv_reg  <= end_row ? pos_rb_reg + coef_b_reg
                                                   : pos_pv_reg + coef_a_reg;
                            pos_rb_reg  <= end_row ? pos_rb_reg + coef_b_reg : pos_rb_reg;
                            state_reg   <= S_SC_RD;
                        end
                    end
                    S_RO_RD:
                    begin
                        state_reg <= S_RO_EV;
                    end
                    S_RO_EV:
                    begin
                        out_data_reg.last_pixel <= pos_end_img;
                        if (phase_reg == PH_PASS)
                        begin
                            out_data_reg.pixel_out <= ram_rdata;
                            out_data_reg.status    <= pfsn_pkg::ST_PASS;
                            out_valid_reg          <= 1'b1;
                            state_reg              <= S_IDLE;
                        end
                        else if (span == '0)
                        begin
                            out_data_reg.pixel_out <= '0;
                            out_data_reg.status    <= pfsn_pkg::ST_OK;
                            out_valid_reg          <= 1'b1;
                            state_reg              <= S_IDLE;
                        end
                        else
                        begin
                            out_data_reg.status <= pfsn_pkg::ST_OK;
                            state_reg           <= S_RO_WT;
                        end
                        if (pos_end_img)
                        begin
                            pos_idx_reg <= '0;
                            pos_j_reg   <= '0;
                            pos_i_reg   <= '0;
                            pos_pv_reg  <= coef_c_reg;
                            pos_rb_reg  <= coef_c_reg;
                        end
                        else
                        begin
                            pos_idx_reg <= pos_idx_reg + 1'b1;
                            pos_j_reg   <= pos_end_row ? '0 : pos_j_reg + 1'b1;
                            pos_i_reg   <= pos_end_row ? pos_i_reg + 1'b1 : pos_i_reg;
                            pos_pv_reg  <= pos_end_row ? pos_rb_reg + coef_b_reg
                                                       : pos_pv_reg + coef_a_reg;
                            pos_rb_reg  <= pos_end_row ? pos_rb_reg + coef_b_reg
                                                       : pos_rb_reg;
                        end
                    end
                    S_RO_WT:
                    begin
                        if (div_done)
                        begin
                            if (div_quo[QW-1])
                            begin
                                out_data_reg.pixel_out <= '0;
                            end
                            else if (|div_quo[QW-2:PW])
                            begin
                                out_data_reg.pixel_out <= '1;
                            end
                            else
                            begin
                                out_data_reg.pixel_out <= div_quo[PW-1:0];
                            end
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    // the divider only runs under the fit and readout states
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_FA_WT || state_reg == S_FB_WT
                      || state_reg == S_FC_WT || state_reg == S_RO_WT))
        else $error("divider busy outside a division state");

    // a fitted image always has an ordered residual range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FITTED) |-> (res_max_reg >= res_min_reg))
        else $error("residual range inverted after fit");

    // a not-loaded answer never marks the end of an image
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == pfsn_pkg::ST_NOT_LOAD)
        |-> !out_data_reg.last_pixel)
        else $error("last pixel flagged on a not-loaded word");
`endif

endmodule
